// File: design/tipc_pkg.sv
package tipc_pkg;

	localparam int COORD_WIDTH = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;

	localparam logic [CFG_INDEX_W-1:0] REG_MAJOR_RADIUS    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MINOR_RADIUS    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_AXIS_PACKED     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CLASS_TOLERANCE = 3'd6;

	localparam logic [15:0] MAJOR_RADIUS_RESET    = 16'd512;
	localparam logic [15:0] MINOR_RADIUS_RESET    = 16'd128;
	localparam logic [47:0] AXIS_PACKED_RESET     = 48'd1073741824;
	localparam logic [31:0] CLASS_TOLERANCE_RESET = 32'd1677;

	// Fixed-point alignment shifts.
	localparam int AXIS_SHIFT  = 28;
	localparam int VALUE_SHIFT = 36;
	localparam int GRAD_SHIFT  = 28;

	localparam int DIFF_W = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
	localparam int DD_W   = 2 * COORD_WIDTH;
	localparam int DA_W   = COORD_WIDTH + 16;
	localparam int DSQ_W  = 2 * COORD_WIDTH + 1;
	localparam int S_W    = ((2 * COORD_WIDTH > 32) ? 2 * COORD_WIDTH : 32) + 2;
	localparam int AX_W   = COORD_WIDTH + 17;
	localparam int S2_W   = 2 * S_W;
	localparam int AX2_W  = 2 * AX_W;
	localparam int SD_W   = S_W + COORD_WIDTH;
	localparam int AXA_W  = AX_W + 16;
	localparam int QR_W   = ((DSQ_W + AXIS_SHIFT > AX2_W) ? DSQ_W + AXIS_SHIFT : AX2_W) + 1;
	localparam int Q_W    = 2 * COORD_WIDTH + AXIS_SHIFT;
	localparam int QL_W   = Q_W / 2;
	localparam int QH_W   = Q_W - QL_W;
	localparam int QP_W   = QH_W + 32;
	localparam int RAD_W  = AXA_W + 1;
	localparam int RL_W   = RAD_W / 2;
	localparam int RH_W   = RAD_W - RL_W;
	localparam int RLO_W  = RL_W + 32;
	localparam int RHI_W  = RH_W + 33;
	localparam int QRS_W  = Q_W + 32;
	localparam int G2_W   = RAD_W + 33;
	localparam int F_W    = ((S2_W + AXIS_SHIFT > QRS_W + 3) ? S2_W + AXIS_SHIFT : QRS_W + 3) + 1;
	localparam int F24_W  = F_W - VALUE_SHIFT;
	localparam int G_W    = ((SD_W + 30 > G2_W + 3) ? SD_W + 30 : G2_W + 3) + 1;
	localparam int GS_W   = G_W - GRAD_SHIFT;
	localparam int CMP_W  = ((F24_W > 33) ? F24_W : 33) + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [DD_W-1:0]        dd_t;
	typedef logic signed [DA_W-1:0]        da_t;
	typedef logic signed [DSQ_W-1:0]       dsq_t;
	typedef logic signed [S_W-1:0]         s_t;
	typedef logic signed [AX_W-1:0]        ax_t;
	typedef logic signed [S2_W-1:0]        s2_t;
	typedef logic signed [AX2_W-1:0]       ax2_t;
	typedef logic signed [SD_W-1:0]        sd_t;
	typedef logic signed [AXA_W-1:0]       axa_t;
	typedef logic signed [QR_W-1:0]        qraw_t;
	typedef logic        [Q_W-1:0]         q_t;
	typedef logic        [QP_W-1:0]        qp_t;
	typedef logic signed [RAD_W-1:0]       rad_t;
	typedef logic        [RLO_W-1:0]       rlo_t;
	typedef logic signed [RHI_W-1:0]       rhi_t;
	typedef logic        [QRS_W-1:0]       qrs_t;
	typedef logic signed [G2_W-1:0]        g2_t;
	typedef logic signed [F_W-1:0]         f_t;
	typedef logic signed [F24_W-1:0]       f24_t;
	typedef logic signed [G_W-1:0]         g_t;
	typedef logic signed [GS_W-1:0]        gs_t;
	typedef logic signed [CMP_W-1:0]       cmp_t;
	typedef logic signed [127:0]           wide_t;
	typedef logic        [31:0]            rsq_t;

	typedef enum logic [1:0] {
		CLASS_INSIDE  = 2'd0,
		CLASS_ON      = 2'd1,
		CLASS_OUTSIDE = 2'd2
	} class_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [63:0] implicit_value;
		logic        [1:0]  point_class;
		logic signed [55:0] grad_x;
		logic signed [55:0] grad_y;
		logic signed [55:0] grad_z;
	} result_t;

	function automatic coord_t local_offset(input coord_t p, input logic signed [15:0] c);
		diff_t diff;
		diff = diff_t'(p) - diff_t'(c);
		if (diff[DIFF_W-1:COORD_WIDTH-1] == '0 || diff[DIFF_W-1:COORD_WIDTH-1] == '1) begin
			return diff[COORD_WIDTH-1:0];
		end else if (diff[DIFF_W-1]) begin
			return {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [63:0] sat_64(input wide_t v);
		if (v[127:63] == '0 || v[127:63] == '1) begin
			return v[63:0];
		end else if (v[127]) begin
			return {1'b1, {63{1'b0}}};
		end else begin
			return {1'b0, {63{1'b1}}};
		end
	endfunction

	function automatic logic signed [55:0] sat_56(input wide_t v);
		if (v[127:55] == '0 || v[127:55] == '1) begin
			return v[55:0];
		end else if (v[127]) begin
			return {1'b1, {55{1'b0}}};
		end else begin
			return {1'b0, {55{1'b1}}};
		end
	endfunction

endpackage

// File: design/torus_implicit_point_classifier_top.sv
// Torus point classifier: one query point in, one result beat out.
// Input channel point_valid/point_ready/point carries a signed Q7.8 point.
// Output channel result_valid/result_ready/result carries the implicit value
// F in Q.24, the inside/on/outside class and the gradient in Q.24.
// Configuration is written through cfg_write_en/cfg_index/cfg_data, one
// register per cycle; write only while no point is in flight, as the block does not enforce it.
// The datapath is a nine-stage pipeline; a point accepted into stage 1 moves
// through stages 2 to 8 into the stage 9 output register when not stalled.
// One point is accepted every cycle while point_ready is high; throughput is set by the
// single shared stall enable across all stages, so it stays at one beat per cycle as long
// as the receiver takes results every cycle.
// When result_valid is high and result_ready is low the whole pipeline holds
// and point_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the register defaults:
// R = 2.0, r = 0.5, center at the origin, axis along y, tolerance 1677.
module torus_implicit_point_classifier_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 point_valid,
	output logic                                 point_ready,
	input  tipc_pkg::point_t                     point,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output tipc_pkg::result_t                    result,
	input  logic                                 cfg_write_en,
	input  logic [tipc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tipc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [15:0]        major_q;
	logic [15:0]        minor_q;
	logic signed [15:0] center_q [3];
	logic [47:0]        axis_q;
	logic [31:0]        tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q     <= tipc_pkg::MAJOR_RADIUS_RESET;
			minor_q     <= tipc_pkg::MINOR_RADIUS_RESET;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			axis_q      <= tipc_pkg::AXIS_PACKED_RESET;
			tol_q       <= tipc_pkg::CLASS_TOLERANCE_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				tipc_pkg::REG_MAJOR_RADIUS:    major_q     <= cfg_data[15:0];
				tipc_pkg::REG_MINOR_RADIUS:    minor_q     <= cfg_data[15:0];
				tipc_pkg::REG_CENTER_X:        center_q[0] <= cfg_data[15:0];
				tipc_pkg::REG_CENTER_Y:        center_q[1] <= cfg_data[15:0];
				tipc_pkg::REG_CENTER_Z:        center_q[2] <= cfg_data[15:0];
				tipc_pkg::REG_AXIS_PACKED:     axis_q      <= cfg_data[47:0];
				tipc_pkg::REG_CLASS_TOLERANCE: tol_q       <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	logic               adv;
	logic signed [15:0] axis_c [3];
	logic [15:0]        major_r;
	logic [15:0]        minor_r;
	tipc_pkg::coord_t   pt [3];

	assign adv         = !result_valid || result_ready;
	assign point_ready = adv;
	assign major_r     = (major_q == '0) ? 16'd1 : major_q;
	assign minor_r     = (minor_q == '0) ? 16'd1 : minor_q;
	assign axis_c[0]   = axis_q[15:0];
	assign axis_c[1]   = axis_q[31:16];
	assign axis_c[2]   = axis_q[47:32];
	assign pt[0]       = point.point_x;
	assign pt[1]       = point.point_y;
	assign pt[2]       = point.point_z;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (adv) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	tipc_pkg::coord_t d_s1 [3];
	tipc_pkg::coord_t d_s2 [3];
	tipc_pkg::coord_t d_s3 [3];
	tipc_pkg::coord_t d_s4 [3];
	tipc_pkg::dd_t    dd_s2 [3];
	tipc_pkg::da_t    da_s2 [3];
	tipc_pkg::rsq_t   rsq_s2, rsq_s3, rsq_s4, rsq_s5;
	tipc_pkg::rsq_t   r2_s2;
	tipc_pkg::dsq_t   dsq_s3, dsq_s4;
	tipc_pkg::s_t     s_s3;
	tipc_pkg::ax_t    ax_s3;
	tipc_pkg::s2_t    s2_s4, s2_s5, s2_s6, s2_s7;
	tipc_pkg::ax2_t   ax2_s4;
	tipc_pkg::sd_t    sd_s4 [3];
	tipc_pkg::sd_t    sd_s5 [3];
	tipc_pkg::sd_t    sd_s6 [3];
	tipc_pkg::sd_t    sd_s7 [3];
	tipc_pkg::axa_t   axa_s4 [3];
	tipc_pkg::q_t     q_s5;
	tipc_pkg::rad_t   rad_s5 [3];
	tipc_pkg::qp_t    qlo_s6, qhi_s6;
	tipc_pkg::rlo_t   rlo_s6 [3];
	tipc_pkg::rhi_t   rhi_s6 [3];
	tipc_pkg::qrs_t   qr_s7;
	tipc_pkg::g2_t    g2_s7 [3];
	tipc_pkg::f24_t   f24_s8;
	tipc_pkg::gs_t    gs_s8 [3];
	tipc_pkg::result_t out_s9;

	tipc_pkg::qraw_t qraw;
	tipc_pkg::f_t    f_full;
	tipc_pkg::g_t    g_full [3];
	tipc_pkg::cmp_t  f_cmp;
	tipc_pkg::cmp_t  tol_cmp;
	tipc_pkg::class_t cls;

	always_comb begin
		qraw = (tipc_pkg::qraw_t'(dsq_s4) <<< tipc_pkg::AXIS_SHIFT)
			- tipc_pkg::qraw_t'(ax2_s4);
		f_full = (tipc_pkg::f_t'(s2_s7) <<< tipc_pkg::AXIS_SHIFT)
			- (tipc_pkg::f_t'($signed({1'b0, qr_s7})) <<< 2);
		for (int i = 0; i < 3; i++) begin
			g_full[i] = (tipc_pkg::g_t'(sd_s7[i]) <<< 30)
				- (tipc_pkg::g_t'(g2_s7[i]) <<< 3);
		end
		f_cmp   = tipc_pkg::cmp_t'(f24_s8);
		tol_cmp = tipc_pkg::cmp_t'($signed({1'b0, tol_q}));
		if (f_cmp > tol_cmp) begin
			cls = tipc_pkg::CLASS_OUTSIDE;
		end else if (f_cmp < -tol_cmp) begin
			cls = tipc_pkg::CLASS_INSIDE;
		end else begin
			cls = tipc_pkg::CLASS_ON;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: local offset from the center.
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= tipc_pkg::local_offset(pt[i], center_q[i]);
			end

			// Stage 2: squares, axis projections and radii squared.
			for (int i = 0; i < 3; i++) begin
				d_s2[i]  <= d_s1[i];
				dd_s2[i] <= tipc_pkg::dd_t'(d_s1[i]) * tipc_pkg::dd_t'(d_s1[i]);
				da_s2[i] <= tipc_pkg::da_t'(d_s1[i]) * tipc_pkg::da_t'(axis_c[i]);
			end
			rsq_s2 <= tipc_pkg::rsq_t'(major_r) * tipc_pkg::rsq_t'(major_r);
			r2_s2  <= tipc_pkg::rsq_t'(minor_r) * tipc_pkg::rsq_t'(minor_r);

			// Stage 3: squared length, s and axial component.
			d_s3   <= d_s2;
			rsq_s3 <= rsq_s2;
			dsq_s3 <= tipc_pkg::dsq_t'(dd_s2[0]) + tipc_pkg::dsq_t'(dd_s2[1])
				+ tipc_pkg::dsq_t'(dd_s2[2]);
			s_s3   <= tipc_pkg::s_t'(dd_s2[0]) + tipc_pkg::s_t'(dd_s2[1])
				+ tipc_pkg::s_t'(dd_s2[2]) + tipc_pkg::s_t'($signed({1'b0, rsq_s2}))
				- tipc_pkg::s_t'($signed({1'b0, r2_s2}));
			ax_s3  <= tipc_pkg::ax_t'(da_s2[0]) + tipc_pkg::ax_t'(da_s2[1])
				+ tipc_pkg::ax_t'(da_s2[2]);

			// Stage 4: second-order products.
			d_s4   <= d_s3;
			dsq_s4 <= dsq_s3;
			rsq_s4 <= rsq_s3;
			s2_s4  <= tipc_pkg::s2_t'(s_s3) * tipc_pkg::s2_t'(s_s3);
			ax2_s4 <= tipc_pkg::ax2_t'(ax_s3) * tipc_pkg::ax2_t'(ax_s3);
			for (int i = 0; i < 3; i++) begin
				sd_s4[i]  <= tipc_pkg::sd_t'(s_s3) * tipc_pkg::sd_t'(d_s3[i]);
				axa_s4[i] <= tipc_pkg::axa_t'(ax_s3) * tipc_pkg::axa_t'(axis_c[i]);
			end

			// Stage 5: perpendicular distance squared and radial vector.
			q_s5   <= qraw[tipc_pkg::QR_W-1] ? '0 : qraw[tipc_pkg::Q_W-1:0];
			s2_s5  <= s2_s4;
			sd_s5  <= sd_s4;
			rsq_s5 <= rsq_s4;
			for (int i = 0; i < 3; i++) begin
				rad_s5[i] <= (tipc_pkg::rad_t'(d_s4[i]) <<< tipc_pkg::AXIS_SHIFT)
					- tipc_pkg::rad_t'(axa_s4[i]);
			end

			// Stage 6: partial products against R squared.
			qlo_s6 <= tipc_pkg::qp_t'(q_s5[tipc_pkg::QL_W-1:0]) * tipc_pkg::qp_t'(rsq_s5);
			qhi_s6 <= tipc_pkg::qp_t'(q_s5[tipc_pkg::Q_W-1:tipc_pkg::QL_W])
				* tipc_pkg::qp_t'(rsq_s5);
			s2_s6  <= s2_s5;
			sd_s6  <= sd_s5;
			for (int i = 0; i < 3; i++) begin
				rlo_s6[i] <= tipc_pkg::rlo_t'(rad_s5[i][tipc_pkg::RL_W-1:0])
					* tipc_pkg::rlo_t'(rsq_s5);
				rhi_s6[i] <= tipc_pkg::rhi_t'($signed(rad_s5[i][tipc_pkg::RAD_W-1:tipc_pkg::RL_W]))
					* tipc_pkg::rhi_t'($signed({1'b0, rsq_s5}));
			end

			// Stage 7: recombine partial products.
			qr_s7 <= tipc_pkg::qrs_t'(qlo_s6)
				+ (tipc_pkg::qrs_t'(qhi_s6) << tipc_pkg::QL_W);
			s2_s7 <= s2_s6;
			sd_s7 <= sd_s6;
			for (int i = 0; i < 3; i++) begin
				g2_s7[i] <= tipc_pkg::g2_t'($signed({1'b0, rlo_s6[i]}))
					+ (tipc_pkg::g2_t'(rhi_s6[i]) <<< tipc_pkg::RL_W);
			end

			// Stage 8: final differences, floored to Q.24.
			f24_s8 <= $signed(f_full[tipc_pkg::F_W-1:tipc_pkg::VALUE_SHIFT]);
			for (int i = 0; i < 3; i++) begin
				gs_s8[i] <= $signed(g_full[i][tipc_pkg::G_W-1:tipc_pkg::GRAD_SHIFT]);
			end

			// Stage 9: saturation and classification into the output register.
			out_s9.implicit_value <= tipc_pkg::sat_64(tipc_pkg::wide_t'(f24_s8));
			out_s9.point_class    <= cls;
			out_s9.grad_x         <= tipc_pkg::sat_56(tipc_pkg::wide_t'(gs_s8[0]));
			out_s9.grad_y         <= tipc_pkg::sat_56(tipc_pkg::wide_t'(gs_s8[1]));
			out_s9.grad_z         <= tipc_pkg::sat_56(tipc_pkg::wide_t'(gs_s8[2]));
		end
	end

	assign result_valid = v_s9;
	assign result       = out_s9;

	a_outside_positive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.point_class == tipc_pkg::CLASS_OUTSIDE
		|-> !result.implicit_value[63])
		else $error("outside class with negative implicit value");

	a_inside_negative: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.point_class == tipc_pkg::CLASS_INSIDE
		|-> result.implicit_value[63])
		else $error("inside class with non-negative implicit value");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!point_ready
		|=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9}))
		else $error("pipeline valid bits moved during a stall");

endmodule
